FILE: rtl/core/ivs_pkg.sv
package ivs_pkg;

  localparam int DEPTH      = 64;
  localparam int WORD_BITS  = 32;
  localparam int IDX_BITS   = $clog2(DEPTH);
  localparam int COUNT_BITS = 7;
  localparam int ITER_BITS  = 8;

  typedef enum logic [3:0] {
    OP_PUSH       = 4'd0,
    OP_INSERT     = 4'd1,
    OP_POP        = 4'd2,
    OP_REMOVE     = 4'd3,
    OP_SET        = 4'd4,
    OP_GET        = 4'd5,
    OP_TRUNCATE   = 4'd6,
    OP_ITER_FRONT = 4'd7,
    OP_ITER_BACK  = 4'd8,
    OP_NEXT       = 4'd9,
    OP_REV_NEXT   = 4'd10
  } ivs_op_t;

  typedef struct packed {
    logic [3:0]            operation;
    logic [COUNT_BITS-1:0] position;
    logic [WORD_BITS-1:0]  data_word;
  } ivs_req_t;

  typedef struct packed {
    logic                  success;
    logic [WORD_BITS-1:0]  read_word;
    logic [COUNT_BITS-1:0] element_count;
  } ivs_rsp_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic                 ins;
    logic                 rem;
    logic                 wr;
    logic [IDX_BITS-1:0]  pos;
    logic [IDX_BITS-1:0]  rd_pos;
    logic [WORD_BITS-1:0] data;
  } ivs_cell_ctl_t;

endpackage

FILE: rtl/core/indexed_vector_store.sv
// indexed vector store: an ordered list of up to 64 words held in a chain of
// cells, one word per cell, each cell shifting to or from its neighbor.
// requests arrive on req with req_valid; a request is taken at a clock edge
// where req_valid is high and req_stall is low. each request gives exactly one
// response on rsp with rsp_valid, taken when rsp_stall is low.
// the response is registered at the edge that takes the request. throughput is
// one request per cycle while req_stall is low, since insert and remove move
// every cell of the chain in parallel.
// the response register frees itself in the same cycle it is taken, so
// req_stall is high only while a response waits under rsp_stall.
// reset clears the count to zero, the iterator to exhausted and rsp_valid;
// the word cells are not cleared and are only ever read below the count.
// while rsp_stall holds, the response stays unchanged and no new request is
// taken.
module indexed_vector_store (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  ivs_pkg::ivs_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output ivs_pkg::ivs_rsp_t rsp
);
  import ivs_pkg::*;

  logic                  accept;
  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0] cnt_next;
  logic [ITER_BITS-1:0]  iter;
  logic [ITER_BITS-1:0]  iter_next;
  logic                  ok;
  logic                  is_read;
  logic                  use_iter;
  logic                  do_ins;
  logic                  do_rem;
  logic                  do_wr;
  logic [IDX_BITS-1:0]   wr_pos;
  logic                  pos_valid;
  logic                  iter_valid;
  ivs_cell_ctl_t         ctl;
  ivs_rsp_t              rsp_next;
  logic [WORD_BITS-1:0]  read_bus;
  logic [WORD_BITS-1:0]  words [DEPTH];
  logic [WORD_BITS-1:0]  taps  [DEPTH];

  assign req_stall = rsp_valid & rsp_stall;
  assign accept    = req_valid & ~req_stall;

  assign pos_valid  = req.position < cnt;
  assign iter_valid = iter < ITER_BITS'(cnt);

  always_comb begin
    ok        = 1'b0;
    is_read   = 1'b0;
    use_iter  = 1'b0;
    do_ins    = 1'b0;
    do_rem    = 1'b0;
    do_wr     = 1'b0;
    wr_pos    = req.position[IDX_BITS-1:0];
    cnt_next  = cnt;
    iter_next = iter;
    unique case (req.operation)
      OP_PUSH: begin
        ok       = cnt < COUNT_BITS'(DEPTH);
        do_wr    = ok;
        wr_pos   = cnt[IDX_BITS-1:0];
        cnt_next = ok ? cnt + 1'b1 : cnt;
      end
      OP_INSERT: begin
        ok       = (req.position <= cnt) && (cnt < COUNT_BITS'(DEPTH));
        do_ins   = ok;
        cnt_next = ok ? cnt + 1'b1 : cnt;
      end
      OP_POP: begin
        ok       = cnt != '0;
        cnt_next = ok ? cnt - 1'b1 : cnt;
      end
      OP_REMOVE: begin
        ok       = pos_valid;
        do_rem   = ok;
        cnt_next = ok ? cnt - 1'b1 : cnt;
      end
      OP_SET: begin
        ok    = pos_valid;
        do_wr = ok;
      end
      OP_GET: begin
        ok      = pos_valid;
        is_read = ok;
      end
      OP_TRUNCATE: begin
        ok       = req.position <= COUNT_BITS'(DEPTH);
        cnt_next = (ok && pos_valid) ? req.position : cnt;
      end
      OP_ITER_FRONT: begin
        ok        = 1'b1;
        iter_next = '0;
      end
      OP_ITER_BACK: begin
        ok        = 1'b1;
        iter_next = ITER_BITS'(cnt) - 1'b1;
      end
      OP_NEXT: begin
        ok        = iter_valid;
        is_read   = ok;
        use_iter  = 1'b1;
        iter_next = ok ? iter + 1'b1 : iter;
      end
      OP_REV_NEXT: begin
        ok        = iter_valid;
        is_read   = ok;
        use_iter  = 1'b1;
        iter_next = ok ? iter - 1'b1 : iter;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    ctl.ins    = accept & do_ins;
    ctl.rem    = accept & do_rem;
    ctl.wr     = accept & do_wr;
    ctl.pos    = wr_pos;
    ctl.rd_pos = use_iter ? iter[IDX_BITS-1:0] : req.position[IDX_BITS-1:0];
    ctl.data   = req.data_word;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] prev_word;
    logic [WORD_BITS-1:0] next_word;
    if (i == 0) begin : g_first
      assign prev_word = req.data_word;
    end else begin : g_prev
      assign prev_word = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_word = words[i];
    end else begin : g_next
      assign next_word = words[i+1];
    end
    ivs_cell u_cell (
      .clk       (clk),
      .index     (IDX_BITS'(i)),
      .ctl       (ctl),
      .prev_word (prev_word),
      .next_word (next_word),
      .word      (words[i]),
      .tap       (taps[i])
    );
  end

  // only the addressed cell drives a nonzero tap
  always_comb begin
    read_bus = '0;
    for (int k = 0; k < DEPTH; k++) begin
      read_bus = read_bus | taps[k];
    end
  end

  always_comb begin
    rsp_next.success       = ok;
    rsp_next.read_word     = is_read ? read_bus : '0;
    rsp_next.element_count = cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      cnt       <= '0;
      iter      <= '1;
    end else begin
      if (accept) begin
        rsp_valid <= 1'b1;
        cnt       <= cnt_next;
        iter      <= iter_next;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

FILE: rtl/core/ivs_cell.sv
module ivs_cell (
  input  logic                          clk,
  input  logic [ivs_pkg::IDX_BITS-1:0]  index,
  input  ivs_pkg::ivs_cell_ctl_t        ctl,
  input  logic [ivs_pkg::WORD_BITS-1:0] prev_word,
  input  logic [ivs_pkg::WORD_BITS-1:0] next_word,
  output logic [ivs_pkg::WORD_BITS-1:0] word,
  output logic [ivs_pkg::WORD_BITS-1:0] tap
);
  import ivs_pkg::*;

  logic [WORD_BITS-1:0] word_next;

  always_comb begin
    word_next = word;
    if (ctl.ins) begin
      // cells above the insert point take their lower neighbor
      if (index > ctl.pos) begin
        word_next = prev_word;
      end else if (index == ctl.pos) begin
        word_next = ctl.data;
      end
    end else if (ctl.rem) begin
      if (index >= ctl.pos) begin
        word_next = next_word;
      end
    end else if (ctl.wr && index == ctl.pos) begin
      word_next = ctl.data;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  assign tap = (index == ctl.rd_pos) ? word : '0;

endmodule

FILE: rtl/core/ivs_checker.sv
module ivs_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_stall,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input ivs_pkg::ivs_rsp_t rsp
);
  import ivs_pkg::*;

  // every taken request shows a response on the next cycle
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> rsp_valid)
    else $error("no response after a taken request");

  // a waiting response blocks new requests
  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |-> req_stall)
    else $error("request taken while response is held");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("held response changed");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.element_count <= COUNT_BITS'(DEPTH))
    else $error("element count above depth");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.success |-> rsp.read_word == '0)
    else $error("refused request returned a word");

endmodule

bind indexed_vector_store ivs_checker u_ivs_checker (.*);
